>>> rtl/core/vmab_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// VM integer ALU and branch unit package
// Shared widths, operation codes and pipeline record types.
// ----------------------------------------------------------------------------
package vmab_pkg;

    localparam int unsigned XLEN      = 32;
    localparam int unsigned KIND_BITS = 5;

    typedef logic [XLEN-1:0]      word_t;
    typedef logic [KIND_BITS-1:0] kind_t;

    typedef enum logic [KIND_BITS-1:0] {
        OP_ADD  = 5'd0,  OP_SUB  = 5'd1,  OP_MUL  = 5'd2,  OP_DIV  = 5'd3,
        OP_MOD  = 5'd4,  OP_NEG  = 5'd5,  OP_AND  = 5'd6,  OP_OR   = 5'd7,
        OP_XOR  = 5'd8,  OP_NOT  = 5'd9,  OP_SHL  = 5'd10, OP_USHR = 5'd11,
        OP_SSHR = 5'd12, OP_SEXS = 5'd13, OP_SEXB = 5'd14, OP_JUMP = 5'd15,
        OP_JZ   = 5'd16, OP_JNZ  = 5'd17, OP_JEQ  = 5'd18, OP_JNE  = 5'd19,
        OP_JLT  = 5'd20, OP_JGT  = 5'd21, OP_JLE  = 5'd22, OP_JGE  = 5'd23,
        OP_JLTU = 5'd24, OP_JGTU = 5'd25, OP_JLEU = 5'd26, OP_JGEU = 5'd27
    } op_t;

    // Everything an operation carries alongside the divider.
    typedef struct packed {
        word_t plain_res;
        logic  is_div;
        logic  is_mod;
        logic  div_zero;
        logic  quo_neg;
        logic  rem_neg;
        logic  taken;
        logic  is_ret;
        word_t target;
    } side_t;

endpackage

>>> rtl/core/vmab_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Operation request channel
// Valid/ready channel carrying one operation and its operands per beat.
// ----------------------------------------------------------------------------
interface vmab_req_if;
    import vmab_pkg::*;

    logic  valid;
    logic  ready;
    kind_t kind;
    word_t operand_a;
    word_t operand_b;
    word_t branch_offset;
    word_t program_counter;

    modport source (output valid, kind, operand_a, operand_b, branch_offset,
                    program_counter, input ready);
    modport sink   (input valid, kind, operand_a, operand_b, branch_offset,
                    program_counter, output ready);
endinterface

>>> rtl/core/vmab_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Operation result channel
// Valid/ready channel carrying one ALU or branch result per beat.
// ----------------------------------------------------------------------------
interface vmab_rsp_if;
    import vmab_pkg::*;

    logic  valid;
    logic  ready;
    word_t result_value;
    logic  divide_by_zero;
    logic  branch_taken;
    logic  branch_is_return;
    word_t branch_target;

    modport source (output valid, result_value, divide_by_zero, branch_taken,
                    branch_is_return, branch_target, input ready);
    modport sink   (input valid, result_value, divide_by_zero, branch_taken,
                    branch_is_return, branch_target, output ready);
endinterface

>>> rtl/core/vmab_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pipelined unsigned divider
// Restoring division, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module vmab_divider (
    input  logic           clk,
    input  logic           en,
    input  vmab_pkg::word_t dividend,
    input  vmab_pkg::word_t divisor,
    output vmab_pkg::word_t quotient,
    output vmab_pkg::word_t remainder
);
    import vmab_pkg::*;

    word_t rem_reg [XLEN];
    word_t quo_reg [XLEN];
    word_t dvs_reg [XLEN];
    word_t rem_next [XLEN];
    word_t quo_next [XLEN];

    always_comb
    begin
        for (int k = 0; k < XLEN; k++)
        begin
            logic [XLEN:0] rem_sh;
            logic          ge;
            word_t         r_in;
            word_t         q_in;
            word_t         d_in;
            r_in = (k == 0) ? '0 : rem_reg[(k == 0) ? 0 : k - 1];
            q_in = (k == 0) ? dividend : quo_reg[(k == 0) ? 0 : k - 1];
            d_in = (k == 0) ? divisor : dvs_reg[(k == 0) ? 0 : k - 1];
            rem_sh = {r_in, q_in[XLEN-1]};
            ge = (rem_sh >= {1'b0, d_in});
            rem_next[k] = ge ? rem_sh[XLEN-1:0] - d_in : rem_sh[XLEN-1:0];
            quo_next[k] = {q_in[XLEN-2:0], ge};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < XLEN; k++)
            begin
                rem_reg[k] <= rem_next[k];
                quo_reg[k] <= quo_next[k];
                dvs_reg[k] <= (k == 0) ? divisor : dvs_reg[(k == 0) ? 0 : k - 1];
            end
        end
    end

    assign quotient  = quo_reg[XLEN-1];
    assign remainder = rem_reg[XLEN-1];
endmodule

>>> rtl/core/vm_integer_alu_branch.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// VM integer ALU and branch unit
// Executes one 32-bit arithmetic, logic or branch-compare operation per beat.
// ----------------------------------------------------------------------------
// Usage: the request channel (req) takes one operation per beat: kind,
// operand_a, operand_b, branch_offset and program_counter. The response
// channel (rsp) returns exactly one beat per request, in order.
// A result becomes valid after passing through the pipeline registers in order:
// the decode/execute register loads at the accepting edge, then 32 divider
// stages and the output register follow. All operations take the same path
// so results stay ordered. Throughput is one beat per cycle; the 32-stage
// restoring divider retires one quotient bit per stage, which sets the depth.
// The pipeline advances as a whole whenever the output register is empty
// or is being taken; while the receiver stalls with a result held, req.ready
// is low and every stage holds. Nothing is dropped or repeated.
// Reset (rst_n low, asynchronous) clears all valid bits; data registers are
// not reset.
// ----------------------------------------------------------------------------
module vm_integer_alu_branch (
    input  logic clk,
    input  logic rst_n,
    vmab_req_if.sink   req,
    vmab_rsp_if.source rsp
);
    import vmab_pkg::*;

    logic adv;
    logic s1_valid_reg;
    side_t s1_side_reg;
    side_t s1_side_next;
    word_t s1_mag_a_reg;
    word_t s1_mag_b_reg;
    logic  div_valid_reg [XLEN];
    side_t div_side_reg [XLEN];
    word_t quotient;
    word_t remainder;
    logic  out_valid_reg;
    word_t out_res_reg, out_res_next;
    logic  out_dz_reg;
    logic  out_taken_reg;
    logic  out_ret_reg;
    word_t out_target_reg;

    // The whole pipe moves together unless a finished result is stuck.
    assign adv       = !out_valid_reg || rsp.ready;
    assign req.ready = adv;

    // Execute stage: everything but the division completes here.
    always_comb
    begin
        word_t a;
        word_t b;
        logic  is_br;
        logic  cond;
        logic  slt_ab;
        logic  slt_ba;
        logic  big_sh;
        a = req.operand_a;
        b = req.operand_b;
        is_br  = 1'b1;
        cond   = 1'b0;
        slt_ab = $signed(a) < $signed(b);
        slt_ba = $signed(b) < $signed(a);
        big_sh = (b >= word_t'(XLEN));
        s1_side_next = '0;
        s1_side_next.quo_neg = a[XLEN-1] ^ b[XLEN-1];
        s1_side_next.rem_neg = a[XLEN-1];
        case (req.kind)
            OP_ADD:  s1_side_next.plain_res = a + b;
            OP_SUB:  s1_side_next.plain_res = a - b;
            OP_MUL:  s1_side_next.plain_res = a * b;
            OP_DIV:
            begin
                s1_side_next.is_div   = 1'b1;
                s1_side_next.div_zero = (b == '0);
            end
            OP_MOD:
            begin
                s1_side_next.is_mod   = 1'b1;
                s1_side_next.div_zero = (b == '0);
            end
            OP_NEG:  s1_side_next.plain_res = '0 - a;
            OP_AND:  s1_side_next.plain_res = a & b;
            OP_OR:   s1_side_next.plain_res = a | b;
            OP_XOR:  s1_side_next.plain_res = a ^ b;
            OP_NOT:  s1_side_next.plain_res = ~a;
            OP_SHL:  s1_side_next.plain_res = big_sh ? '0 : a << b[4:0];
            OP_USHR: s1_side_next.plain_res = big_sh ? '0 : a >> b[4:0];
            OP_SSHR: s1_side_next.plain_res = big_sh ? {XLEN{a[XLEN-1]}}
                                                      : word_t'($signed(a) >>> b[4:0]);
            OP_SEXS: s1_side_next.plain_res = {{16{a[15]}}, a[15:0]};
            OP_SEXB: s1_side_next.plain_res = {{24{a[7]}}, a[7:0]};
            OP_JUMP: cond = 1'b1;
            OP_JZ:   cond = (a == '0);
            OP_JNZ:  cond = (a != '0);
            OP_JEQ:  cond = (a == b);
            OP_JNE:  cond = (a != b);
            OP_JLT:  cond = slt_ab;
            OP_JGT:  cond = slt_ba;
            OP_JLE:  cond = !slt_ba;
            OP_JGE:  cond = !slt_ab;
            OP_JLTU: cond = (a < b);
            OP_JGTU: cond = (a > b);
            OP_JLEU: cond = (a <= b);
            OP_JGEU: cond = (a >= b);
            default: is_br = 1'b0;
        endcase
        if (req.kind < OP_JUMP)
        begin
            is_br = 1'b0;
        end
        s1_side_next.taken = is_br && cond;
        if (is_br && cond)
        begin
            if (req.branch_offset == word_t'(0) || req.branch_offset == word_t'(1))
            begin
                s1_side_next.is_ret = 1'b1;
            end
            else
            begin
                s1_side_next.target = req.program_counter + req.branch_offset
                                      - word_t'(2);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < XLEN; k++)
            begin
                div_valid_reg[k] <= 1'b0;
            end
        end
        else if (adv)
        begin
            s1_valid_reg  <= req.valid;
            out_valid_reg <= div_valid_reg[XLEN-1];
            for (int k = 0; k < XLEN; k++)
            begin
                div_valid_reg[k] <= (k == 0) ? s1_valid_reg
                                             : div_valid_reg[(k == 0) ? 0 : k - 1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_side_reg  <= s1_side_next;
            s1_mag_a_reg <= req.operand_a[XLEN-1] ? '0 - req.operand_a : req.operand_a;
            s1_mag_b_reg <= req.operand_b[XLEN-1] ? '0 - req.operand_b : req.operand_b;
            for (int k = 0; k < XLEN; k++)
            begin
                div_side_reg[k] <= (k == 0) ? s1_side_reg
                                            : div_side_reg[(k == 0) ? 0 : k - 1];
            end
            out_res_reg    <= out_res_next;
            out_dz_reg     <= div_side_reg[XLEN-1].div_zero;
            out_taken_reg  <= div_side_reg[XLEN-1].taken;
            out_ret_reg    <= div_side_reg[XLEN-1].is_ret;
            out_target_reg <= div_side_reg[XLEN-1].target;
        end
    end

    vmab_divider u_div (
        .clk       (clk),
        .en        (adv),
        .dividend  (s1_mag_a_reg),
        .divisor   (s1_mag_b_reg),
        .quotient  (quotient),
        .remainder (remainder)
    );

    // Sign correction of the division result and final selection.
    always_comb
    begin
        side_t sd;
        sd = div_side_reg[XLEN-1];
        if (sd.div_zero)
        begin
            out_res_next = '0;
        end
        else if (sd.is_div)
        begin
            out_res_next = sd.quo_neg ? '0 - quotient : quotient;
        end
        else if (sd.is_mod)
        begin
            out_res_next = sd.rem_neg ? '0 - remainder : remainder;
        end
        else
        begin
            out_res_next = sd.plain_res;
        end
    end

    assign rsp.valid            = out_valid_reg;
    assign rsp.result_value     = out_res_reg;
    assign rsp.divide_by_zero   = out_dz_reg;
    assign rsp.branch_taken     = out_taken_reg;
    assign rsp.branch_is_return = out_ret_reg;
    assign rsp.branch_target    = out_target_reg;
endmodule
